### rtl/core/tts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tridiagonal solver package
// Shared constants, codes and control types for the tridiagonal solver.
// ----------------------------------------------------------------------------
package tts_pkg;

	localparam int DefMaxSize    = 64;
	localparam int DefValueWidth = 32;
	localparam int FracBits      = 16;
	localparam int CfgIdxWidth   = 2;
	localparam int CfgDataWidth  = 32;
	localparam int SizeWidth     = 7;

	localparam logic [CfgIdxWidth-1:0] RegDiagonal = 2'd0;
	localparam logic [CfgIdxWidth-1:0] RegSize     = 2'd1;
	localparam logic [CfgIdxWidth-1:0] RegStartNeu = 2'd2;
	localparam logic [CfgIdxWidth-1:0] RegEndNeu   = 2'd3;

	typedef struct packed {
		logic load_row;
		logic piv_calc;
		logic div_start;
		logic div_sel_y;
		logic y_write;
		logic bs_init;
		logic bs_read;
		logic bs_mul;
		logic bs_upd;
		logic out_emit;
		logic solve_end;
	} tts_cmd_t;

	typedef struct packed {
		logic div_done;
		logic row_last;
		logic bs_first;
		logic bs_zero;
	} tts_sts_t;

endpackage
`default_nettype wire

### rtl/core/tts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tridiagonal solver controller
// Sequences one forward-sweep row per item and the back substitution.
// ----------------------------------------------------------------------------
module tts_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  tts_pkg::tts_sts_t    sts,
	output tts_pkg::tts_cmd_t    cmd
);
	import tts_pkg::*;

	localparam logic [3:0] StIdle  = 4'd0;
	localparam logic [3:0] StPiv   = 4'd1;
	localparam logic [3:0] StDivC  = 4'd2;
	localparam logic [3:0] StWaitC = 4'd3;
	localparam logic [3:0] StDivY  = 4'd4;
	localparam logic [3:0] StWaitY = 4'd5;
	localparam logic [3:0] StBsRd  = 4'd6;
	localparam logic [3:0] StBsMul = 4'd7;
	localparam logic [3:0] StBsUpd = 4'd8;
	localparam logic [3:0] StOut   = 4'd9;
	localparam logic [3:0] StOutRd = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			StIdle: begin
				if (start) begin
					cmd.load_row = 1'b1;
					state_d = StPiv;
				end
			end
			StPiv: begin
				cmd.piv_calc = 1'b1;
				state_d = sts.row_last ? StDivY : StDivC;
			end
			StDivC: begin
				cmd.div_start = 1'b1;
				state_d = StWaitC;
			end
			StWaitC: begin
				if (sts.div_done) state_d = StDivY;
			end
			StDivY: begin
				cmd.div_start = 1'b1;
				cmd.div_sel_y = 1'b1;
				state_d = StWaitY;
			end
			StWaitY: begin
				cmd.div_sel_y = 1'b1;
				if (sts.div_done) begin
					cmd.y_write = 1'b1;
					if (sts.row_last) begin
						cmd.bs_init = 1'b1;
						state_d = sts.bs_zero ? StOutRd : StBsRd;
					end else begin
						state_d = StIdle;
					end
				end
			end
			StBsRd: begin
				cmd.bs_read = 1'b1;
				state_d = StBsMul;
			end
			StBsMul: begin
				cmd.bs_mul = 1'b1;
				state_d = StBsUpd;
			end
			StBsUpd: begin
				cmd.bs_upd = 1'b1;
				state_d = sts.bs_zero ? StOutRd : StBsRd;
			end
			StOutRd: begin
				cmd.bs_read = 1'b1;
				state_d = StOut;
			end
			StOut: begin
				cmd.out_emit = 1'b1;
				if (sts.bs_first) begin
					cmd.solve_end = 1'b1;
					state_d = StIdle;
				end else begin
					state_d = StOutRd;
				end
			end
			default: state_d = StIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= StIdle;
		else state_q <= state_d;
	end

	assign busy = (state_q != StIdle);

endmodule
`default_nettype wire

### rtl/core/tts_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tridiagonal solver divider
// Radix-2 restoring divider for saturating signed fixed-point quotients.
// ----------------------------------------------------------------------------
module tts_div #(
	parameter int ValueWidth = tts_pkg::DefValueWidth
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         go,
	input  wire logic signed [ValueWidth-1:0] num,
	input  wire logic signed [ValueWidth-1:0] den,
	output logic                              done,
	output logic signed [ValueWidth-1:0]      quo,
	output logic                              sat
);
	import tts_pkg::*;

	localparam int NumW = ValueWidth + FracBits;
	localparam int CntW = $clog2(NumW + 1);
	localparam logic signed [ValueWidth-1:0] VMax = {1'b0, {(ValueWidth-1){1'b1}}};
	localparam logic signed [ValueWidth-1:0] VMin = {1'b1, {(ValueWidth-1){1'b0}}};

	logic [NumW-1:0]       dvd_q;
	logic [ValueWidth-1:0] dvs_q;
	logic [ValueWidth:0]   rem_q;
	logic [CntW-1:0]       cnt_q;
	logic                  neg_q;
	logic                  zero_q;
	logic                  nneg_q;
	logic                  run_q;
	logic [ValueWidth:0]   trial;
	logic [ValueWidth:0]   rem_sh;
	logic [NumW:0]         mag;
	logic [ValueWidth-1:0] an;
	logic [ValueWidth-1:0] ad;

	assign an     = num[ValueWidth-1] ? ValueWidth'(-num) : ValueWidth'(num);
	assign ad     = den[ValueWidth-1] ? ValueWidth'(-den) : ValueWidth'(den);
	assign rem_sh = {rem_q[ValueWidth-1:0], dvd_q[NumW-1]};
	assign trial  = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CntW'(NumW);
			end else if (run_q) begin
				if (cnt_q == CntW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q  <= {an, {FracBits{1'b0}}};
			dvs_q  <= ad;
			rem_q  <= '0;
			neg_q  <= num[ValueWidth-1] ^ den[ValueWidth-1];
			zero_q <= (den == '0);
			nneg_q <= ~num[ValueWidth-1];
		end else if (run_q) begin
			if (!trial[ValueWidth]) begin
				rem_q <= trial;
				dvd_q <= {dvd_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				dvd_q <= {dvd_q[NumW-2:0], 1'b0};
			end
		end
	end

	assign mag = {1'b0, dvd_q};

	always_comb begin
		sat = 1'b0;
		quo = '0;
		if (zero_q) begin
			sat = 1'b1;
			quo = nneg_q ? VMax : VMin;
		end else if (!neg_q) begin
			if (mag > (NumW+1)'(VMax)) begin
				sat = 1'b1;
				quo = VMax;
			end else begin
				quo = ValueWidth'(mag);
			end
		end else begin
			if (mag > ((NumW+1)'(VMax) + (NumW+1)'(1))) begin
				sat = 1'b1;
				quo = VMin;
			end else begin
				quo = ValueWidth'(-mag);
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/tts_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tridiagonal solver datapath
// Configuration, row stores, pivot logic, divider and back substitution.
// ----------------------------------------------------------------------------
module tts_dp #(
	parameter int MaxSize    = tts_pkg::DefMaxSize,
	parameter int ValueWidth = tts_pkg::DefValueWidth
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	input  wire logic [tts_pkg::CfgIdxWidth-1:0]     cfg_index,
	input  wire logic [tts_pkg::CfgDataWidth-1:0]    cfg_data,
	input  wire logic signed [ValueWidth-1:0]        rhs_value,
	input  tts_pkg::tts_cmd_t                        cmd,
	output tts_pkg::tts_sts_t                        sts,
	output logic                                     result_valid,
	output logic signed [ValueWidth-1:0]             solution_value,
	output logic                                     last_item,
	output logic                                     divide_fault
);
	import tts_pkg::*;

	localparam int IdxW = $clog2(MaxSize);
	localparam int WW   = ValueWidth + 2;
	localparam int PW   = 2 * ValueWidth;
	localparam logic signed [WW-1:0] VMaxW = WW'({1'b0, {(ValueWidth-1){1'b1}}});
	localparam logic signed [WW-1:0] VMinW = -VMaxW - WW'(1);
	localparam logic signed [WW-1:0] OneW  = WW'(1) <<< FracBits;
	localparam logic signed [PW-1:0] VMaxP = PW'(VMaxW);
	localparam logic signed [PW-1:0] VMinP = PW'(VMinW);
	localparam logic signed [PW-1:0] RndP  = PW'((1 << FracBits) - 1);

	function automatic logic signed [ValueWidth-1:0] clampw(input logic signed [WW-1:0] v);
		if (v > VMaxW) return VMaxW[ValueWidth-1:0];
		if (v < VMinW) return VMinW[ValueWidth-1:0];
		return v[ValueWidth-1:0];
	endfunction

	logic signed [ValueWidth-1:0] diag_q;
	logic [SizeWidth-1:0]         size_q;
	logic                         sneu_q;
	logic                         eneu_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diag_q <= ValueWidth'(262144);
			size_q <= SizeWidth'(64);
			sneu_q <= 1'b0;
			eneu_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				RegDiagonal: diag_q <= ValueWidth'($signed(cfg_data));
				RegSize:     size_q <= cfg_data[SizeWidth-1:0];
				RegStartNeu: sneu_q <= cfg_data[0];
				RegEndNeu:   eneu_q <= cfg_data[0];
				default:     ;
			endcase
		end
	end

	logic signed [ValueWidth-1:0] c_mem [MaxSize];
	logic signed [ValueWidth-1:0] y_mem [MaxSize];

	logic [IdxW-1:0]              row_q;
	logic                         fault_q;
	logic signed [ValueWidth-1:0] rhs_q;
	logic signed [ValueWidth-1:0] cprev_q;
	logic signed [ValueWidth-1:0] yprev_q;
	logic signed [ValueWidth-1:0] piv_q;
	logic signed [ValueWidth-1:0] numy_q;
	logic                         last_q;
	logic [SizeWidth-1:0]         n_eff;
	logic                         row_last;

	always_comb begin
		n_eff = size_q;
		if (size_q < SizeWidth'(2)) n_eff = SizeWidth'(2);
		if (size_q > SizeWidth'(MaxSize)) n_eff = SizeWidth'(MaxSize);
	end
	assign row_last = (SizeWidth'(row_q) + SizeWidth'(1) >= n_eff)
		|| (row_q == IdxW'(MaxSize - 1));

	logic                         div_done;
	logic signed [ValueWidth-1:0] div_quo;
	logic                         div_sat;

	tts_div #(.ValueWidth(ValueWidth)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.div_start),
		.num    (cmd.div_sel_y ? numy_q : ValueWidth'(OneW)),
		.den    (piv_q),
		.done   (div_done),
		.quo    (div_quo),
		.sat    (div_sat)
	);

	logic signed [WW-1:0] piv_w;
	always_comb begin
		if (row_q == '0)
			piv_w = WW'(diag_q) + (sneu_q ? OneW : WW'(0));
		else
			piv_w = WW'(diag_q) - WW'(cprev_q) + ((row_last && eneu_q) ? OneW : WW'(0));
	end

	logic [IdxW-1:0]              bs_q;
	logic signed [ValueWidth-1:0] x_q;
	logic signed [ValueWidth-1:0] rd_c_q;
	logic signed [ValueWidth-1:0] rd_y_q;
	logic signed [PW-1:0]         prod_s1;
	logic signed [PW-1:0]         pq;
	logic signed [ValueWidth-1:0] pq_sat;

	// The shift rounds toward minus infinity, so negative products get a bias first.
	assign pq = (prod_s1 + (prod_s1[PW-1] ? RndP : PW'(0))) >>> FracBits;

	always_comb begin
		if (pq > VMaxP) pq_sat = VMaxW[ValueWidth-1:0];
		else if (pq < VMinP) pq_sat = VMinW[ValueWidth-1:0];
		else pq_sat = pq[ValueWidth-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_row) rhs_q <= rhs_value;
		if (cmd.piv_calc) begin
			piv_q  <= clampw(piv_w);
			numy_q <= (row_q == '0) ? rhs_q : clampw(WW'(rhs_q) - WW'(yprev_q));
			last_q <= row_last;
		end
		if (div_done && !cmd.div_sel_y) begin
			c_mem[row_q] <= div_quo;
			cprev_q      <= div_quo;
		end
		if (cmd.y_write) begin
			y_mem[row_q] <= div_quo;
			yprev_q      <= div_quo;
			if (cmd.bs_init) x_q <= div_quo;
		end
		if (cmd.bs_read) begin
			rd_c_q <= c_mem[bs_q];
			rd_y_q <= y_mem[bs_q];
		end
		if (cmd.bs_mul) prod_s1 <= PW'(rd_c_q) * PW'(x_q);
		if (cmd.bs_upd) begin
			x_q <= clampw(WW'(rd_y_q) - WW'(pq_sat));
			y_mem[bs_q] <= clampw(WW'(rd_y_q) - WW'(pq_sat));
		end
		if (cmd.out_emit) solution_value <= rd_y_q;
	end

	logic piv_sat;
	assign piv_sat = (piv_w > VMaxW) || (piv_w < VMinW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q        <= '0;
			fault_q      <= 1'b0;
			bs_q         <= '0;
			result_valid <= 1'b0;
			last_item    <= 1'b0;
			divide_fault <= 1'b0;
		end else begin
			result_valid <= cmd.out_emit;
			if (cmd.out_emit) begin
				last_item    <= cmd.solve_end;
				divide_fault <= fault_q;
			end
			if (cmd.piv_calc && piv_sat) fault_q <= 1'b1;
			if (div_done && div_sat) fault_q <= 1'b1;
			if (cmd.y_write && !last_q) row_q <= row_q + IdxW'(1);
			if (cmd.bs_init) bs_q <= (row_q == '0) ? '0 : row_q - IdxW'(1);
			if (cmd.bs_upd && bs_q != '0) bs_q <= bs_q - IdxW'(1);
			if (cmd.out_emit) begin
				if (cmd.solve_end) begin
					row_q   <= '0;
					fault_q <= 1'b0;
				end else begin
					bs_q <= bs_q + IdxW'(1);
				end
			end
		end
	end

	assign sts.div_done = div_done;
	assign sts.row_last = (cmd.piv_calc) ? row_last : last_q;
	assign sts.bs_first = (bs_q == row_q);
	assign sts.bs_zero  = cmd.bs_init ? (row_q == '0) : (bs_q == '0);

endmodule
`default_nettype wire

### rtl/core/tridiagonal_thomas_solver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tridiagonal Thomas solver
// Fixed-point solver for a constant-diagonal tridiagonal system.
// ----------------------------------------------------------------------------
// Each right-hand-side item runs one forward-sweep row through a radix-2
// divider of VALUE_WIDTH+16 steps, two divisions for every row but the last,
// and busy stays high until the row is done. The last row needs one
// division and then runs back substitution and emits the solution in index
// order, each item marked by result_valid for one cycle; the receiver
// cannot stall.
module tridiagonal_thomas_solver #(
	parameter int MAX_SIZE    = tts_pkg::DefMaxSize,
	parameter int VALUE_WIDTH = tts_pkg::DefValueWidth
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic signed [VALUE_WIDTH-1:0]       rhs_value,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [tts_pkg::CfgIdxWidth-1:0]     cfg_index,
	input  wire logic [tts_pkg::CfgDataWidth-1:0]    cfg_data,
	output logic                                     result_valid,
	output logic signed [VALUE_WIDTH-1:0]            solution_value,
	output logic                                     last_item,
	output logic                                     divide_fault
);
	import tts_pkg::*;

	tts_cmd_t cmd;
	tts_sts_t sts;

	assign cfg_ready = 1'b1;

	tts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	tts_dp #(.MaxSize(MAX_SIZE), .ValueWidth(VALUE_WIDTH)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.rhs_value      (rhs_value),
		.cmd            (cmd),
		.sts            (sts),
		.result_valid   (result_valid),
		.solution_value (solution_value),
		.last_item      (last_item),
		.divide_fault   (divide_fault)
	);

endmodule
`default_nettype wire

### rtl/core/tts_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tridiagonal solver checker
// Port-level properties of the solver, bound to the top level.
// ----------------------------------------------------------------------------
module tts_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic result_valid,
	input wire logic last_item
);
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted item did not raise busy");
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy)) else $error("result while idle");
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_item) |=> !result_valid) else $error("result after last");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("back-to-back results");
endmodule

bind tridiagonal_thomas_solver tts_checker u_tts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.last_item    (last_item)
);
`default_nettype wire
